// ===== rtl/h2rgbw_pkg.sv =====
// Shared types, constants and elaboration-time table math for the hsi to rgbw converter.
// No dependencies.
package h2rgbw_pkg;

    localparam int unsigned RATIO_FRAC_BITS_DEF = 14;
    localparam int unsigned HUE_WRAP            = 360;
    localparam int unsigned SECTOR_DEG          = 120;
    localparam int unsigned SAT_ONE             = 256;
    localparam int unsigned INT_LIMIT           = 512;
    localparam int unsigned CHAN_MAX            = 255;
    localparam longint unsigned PI_Q30          = 64'd3373259426;
    localparam longint unsigned ONE_Q30         = 64'd1073741824;

    // which channel leads the hue sector
    typedef enum logic [1:0] {
        SECT_RED_LEAD,
        SECT_GREEN_LEAD,
        SECT_BLUE_LEAD
    } sector_t;

    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [9:0] saturation;
        logic [9:0] intensity;
    } hsi_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } rgbw_t;

    // unsigned shift-subtract division, used only while building tables
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // |cos(d degrees)| in q.30 for d in 0..90, truncated taylor series
    function automatic longint unsigned cos_q30(input int unsigned d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned step;
        longint          acc;
        x    = div_u64(longint'(d) * PI_Q30, 64'd180);
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int unsigned n = 1; n <= 12; n++)
        begin
            step = longint'((2 * n - 1) * (2 * n));
            term = div_u64((term * x2) >> 30, step);
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return longint'(acc);
    endfunction

    // cos(a)/cos(60-a) for a in 0..119, signed, frac fraction bits
    function automatic longint ratio_entry(input int unsigned a, input int unsigned frac);
        logic            neg;
        int unsigned     na;
        int unsigned     da;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        neg = (a > 90);
        na  = neg ? 180 - a : a;
        da  = (a > 60) ? a - 60 : 60 - a;
        num = cos_q30(na);
        den = cos_q30(da);
        if (den == 0)
            den = 1;
        mag = div_u64((num << frac) + (den >> 1), den);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

endpackage

// ===== rtl/hsi_to_rgbw_converter_core.sv =====
// Hsi to rgbw converter top: five-stage pipeline, one pixel per clock unless stalled.
// Depends on h2rgbw_pkg.
//
// Takes one hue/saturation/intensity beat per clock and returns red, green, blue and white
// drive bytes from the last stage; with rgbw_ready held high the block sustains one pixel
// every cycle. The work is split into five registered stages: hue wrap and sector split
// with input clamping, the ratio table lookup and the saturation-intensity products, the
// scale by 255 and the white channel, the two ratio multipliers, and the divide by three
// with clamping and channel routing into the output register. Every stage carries its
// own valid bit and only moves when the stage after it has room, so a stalled output
// holds its beat while earlier stages keep filling bubbles. The lead and next factor tables
// hold 120 entries each and are built at elaboration from RATIO_FRAC_BITS.
module hsi_to_rgbw_converter_core #(
    parameter int unsigned RATIO_FRAC_BITS = h2rgbw_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsi_valid,
    output logic              hsi_ready,
    input  h2rgbw_pkg::hsi_t  hsi,
    output logic              rgbw_valid,
    input  logic              rgbw_ready,
    output h2rgbw_pkg::rgbw_t rgbw
);
    import h2rgbw_pkg::*;

    localparam int unsigned FW = RATIO_FRAC_BITS + 2;   // lead/next factor width
    localparam int unsigned PW = 25 + FW;               // ratio product width
    localparam int unsigned QW = 11;                    // product after the 2^(16+F) shift
    localparam logic [QW-1:0] Q_CLAMP = QW'(3 * (CHAN_MAX + 1));
    localparam logic [11:0]   RECIP3  = 12'd2731;      // 2^13/3 rounded up

    typedef logic [FW-1:0] lut_t [SECTOR_DEG];

    // lead factor (1 + ratio) or next factor (2 - ratio), clamped at zero
    function automatic lut_t build_lut(input logic want_next);
        lut_t   t;
        longint r;
        longint one;
        longint f;
        one = longint'(1) << RATIO_FRAC_BITS;
        for (int unsigned a = 0; a < SECTOR_DEG; a++)
        begin
            r = ratio_entry(a, RATIO_FRAC_BITS);
            f = want_next ? (2 * one - r) : (one + r);
            if (f < 0)
                f = 0;
            t[a] = FW'(f);
        end
        return t;
    endfunction

    localparam lut_t LEAD_LUT = build_lut(1'b0);
    localparam lut_t NEXT_LUT = build_lut(1'b1);

    // stage valids and ready chain
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;

    assign out_rdy   = !out_vld_reg || rgbw_ready;
    assign s4_rdy    = !s4_vld_reg || out_rdy;
    assign s3_rdy    = !s3_vld_reg || s4_rdy;
    assign s2_rdy    = !s2_vld_reg || s3_rdy;
    assign s1_rdy    = !s1_vld_reg || s2_rdy;
    assign hsi_ready = s1_rdy;
    assign rgbw_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
                s1_vld_reg <= hsi_valid;
            if (s2_rdy)
                s2_vld_reg <= s1_vld_reg;
            if (s3_rdy)
                s3_vld_reg <= s2_vld_reg;
            if (s4_rdy)
                s4_vld_reg <= s3_vld_reg;
            if (out_rdy)
                out_vld_reg <= s4_vld_reg;
        end
    end

    // stage 1: hue wrap, sector split, input clamps
    logic [8:0] hue_wrap;
    sector_t    s1_sector_next, s1_sector_reg;
    logic [6:0] s1_angle_next, s1_angle_reg;
    logic [8:0] s1_sat_next, s1_sat_reg;
    logic [9:0] s1_int_next, s1_int_reg;

    always_comb
    begin
        hue_wrap = (hsi.hue_degrees >= 9'(HUE_WRAP)) ? hsi.hue_degrees - 9'(HUE_WRAP)
                                                    : hsi.hue_degrees;
        if (hue_wrap >= 9'(2 * SECTOR_DEG))
        begin
            s1_sector_next = SECT_BLUE_LEAD;
            s1_angle_next  = 7'(hue_wrap - 9'(2 * SECTOR_DEG));
        end
        else if (hue_wrap >= 9'(SECTOR_DEG))
        begin
            s1_sector_next = SECT_GREEN_LEAD;
            s1_angle_next  = 7'(hue_wrap - 9'(SECTOR_DEG));
        end
        else
        begin
            s1_sector_next = SECT_RED_LEAD;
            s1_angle_next  = hue_wrap[6:0];
        end
        s1_sat_next = (hsi.saturation > 10'(SAT_ONE)) ? 9'(SAT_ONE) : hsi.saturation[8:0];
        s1_int_next = (hsi.intensity > 10'(INT_LIMIT)) ? 10'(INT_LIMIT) : hsi.intensity;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_angle_reg  <= s1_angle_next;
            s1_sat_reg    <= s1_sat_next;
            s1_int_reg    <= s1_int_next;
        end
    end

    // stage 2: ratio lookup, saturation and intensity products
    sector_t       s2_sector_reg;
    logic [FW-1:0] s2_lead_reg, s2_next_reg;
    logic [17:0]   s2_si_reg, s2_sw_reg;
    logic [18:0]   si_full, sw_full;
    logic [8:0]    sat_inv;

    always_comb
    begin
        sat_inv = 9'(SAT_ONE) - s1_sat_reg;
        si_full = 19'(s1_sat_reg) * 19'(s1_int_reg);
        sw_full = 19'(sat_inv) * 19'(s1_int_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_lead_reg   <= LEAD_LUT[s1_angle_reg];
            s2_next_reg   <= NEXT_LUT[s1_angle_reg];
            s2_si_reg     <= si_full[17:0];
            s2_sw_reg     <= sw_full[17:0];
        end
    end

    // stage 3: scale by 255, white channel
    sector_t       s3_sector_reg;
    logic [FW-1:0] s3_lead_reg, s3_next_reg;
    logic [24:0]   s3_base_reg;
    logic [7:0]    s3_white_reg;
    logic [24:0]   base_next;
    logic [24:0]   white_full;
    logic [8:0]    white_raw;

    always_comb
    begin
        base_next  = (25'(s2_si_reg) << 8) - 25'(s2_si_reg);
        white_full = (25'(s2_sw_reg) << 8) - 25'(s2_sw_reg);
        white_raw  = white_full[24:16];
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_lead_reg   <= s2_lead_reg;
            s3_next_reg   <= s2_next_reg;
            s3_base_reg   <= base_next;
            s3_white_reg  <= (white_raw > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : white_raw[7:0];
        end
    end

    // stage 4: ratio multipliers, drop the fixed-point fraction
    sector_t       s4_sector_reg;
    logic [QW-1:0] s4_lead_q_reg, s4_next_q_reg;
    logic [7:0]    s4_white_reg;
    logic [PW-1:0] lead_prod, next_prod;

    always_comb
    begin
        lead_prod = PW'(s3_base_reg) * PW'(s3_lead_reg);
        next_prod = PW'(s3_base_reg) * PW'(s3_next_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s4_rdy)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_lead_q_reg <= lead_prod[PW-1 -: QW];
            s4_next_q_reg <= next_prod[PW-1 -: QW];
            s4_white_reg  <= s3_white_reg;
        end
    end

    // stage 5: divide by three with clamp, route channels
    logic [21:0] lead_div, next_div;
    logic [7:0]  lead_ch, next_ch;
    rgbw_t       out_next, out_reg;

    always_comb
    begin
        lead_div = 22'(s4_lead_q_reg[9:0]) * 22'(RECIP3);
        next_div = 22'(s4_next_q_reg[9:0]) * 22'(RECIP3);
        lead_ch  = (s4_lead_q_reg >= Q_CLAMP) ? 8'(CHAN_MAX) : lead_div[20:13];
        next_ch  = (s4_next_q_reg >= Q_CLAMP) ? 8'(CHAN_MAX) : next_div[20:13];
        out_next.white = s4_white_reg;
        case (s4_sector_reg)
            SECT_RED_LEAD:
            begin
                out_next.red   = lead_ch;
                out_next.green = next_ch;
                out_next.blue  = 8'd0;
            end
            SECT_GREEN_LEAD:
            begin
                out_next.red   = 8'd0;
                out_next.green = lead_ch;
                out_next.blue  = next_ch;
            end
            SECT_BLUE_LEAD:
            begin
                out_next.red   = next_ch;
                out_next.green = 8'd0;
                out_next.blue  = lead_ch;
            end
            default:
            begin
                out_next.red   = 8'd0;
                out_next.green = 8'd0;
                out_next.blue  = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
            out_reg <= out_next;
    end

    assign rgbw = out_reg;

    // checks
    a_unused_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rgbw_valid |-> (rgbw.red == 8'd0 || rgbw.green == 8'd0 || rgbw.blue == 8'd0))
        else $error("no channel is zero in an output beat");

    a_full_flow: assert property (@(posedge clk) disable iff (!rst_n)
        rgbw_ready |-> hsi_ready)
        else $error("input stalled while output is being drained");

    a_stage1_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (s1_sat_reg <= 9'(SAT_ONE) && s1_int_reg <= 10'(INT_LIMIT)
                        && s1_angle_reg < 7'(SECTOR_DEG)))
        else $error("stage one holds an unclamped value");

    a_stage4_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (s4_lead_q_reg <= 11'd1530 && s4_next_q_reg <= 11'd1530))
        else $error("ratio product out of range");

endmodule

// ===== tb/hsi_to_rgbw_converter_core_test.sv =====
// Self-checking testbench for hsi_to_rgbw_converter_core: a directed table, then random pixels,
// compared against a hand-checked result where a row has one, else a built-in model of the conversion.
// Depends on h2rgbw_pkg and the rtl top level hsi_to_rgbw_converter_core.
module hsi_to_rgbw_converter_core_test;

    import h2rgbw_pkg::*;

    localparam int unsigned FRAC        = RATIO_FRAC_BITS_DEF;
    localparam int          NUM_RANDOM  = 2000;
    localparam int          CALM_START  = 1700;
    localparam int          STALL_LIMIT = 1000;
    localparam int          DRAIN_WAIT  = 20;
    localparam int          NUM_PROBES  = 25;

    // one row of the directed table; known rows carry a hand-checked result
    typedef struct packed {
        hsi_t  px;
        logic  known;
        rgbw_t want;
    } probe_t;

    localparam probe_t PROBES [NUM_PROBES] = '{
        '{'{9'd0,   10'd0,    10'd0},    1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{9'd0,   10'd0,    10'd256},  1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{'{9'd200, 10'd0,    10'd512},  1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{'{9'd359, 10'd0,    10'd1023}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
        '{'{9'd0,   10'd256,  10'd0},    1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{9'd511, 10'd1023, 10'd0},    1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{'{9'd0,   10'd256,  10'd256},  1'b0, '0},
        '{'{9'd60,  10'd256,  10'd256},  1'b0, '0},
        '{'{9'd90,  10'd256,  10'd256},  1'b0, '0},
        '{'{9'd91,  10'd256,  10'd256},  1'b0, '0},
        '{'{9'd119, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd120, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd180, 10'd256,  10'd512},  1'b0, '0},
        '{'{9'd239, 10'd256,  10'd512},  1'b0, '0},
        '{'{9'd240, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd300, 10'd128,  10'd256},  1'b0, '0},
        '{'{9'd359, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd360, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd480, 10'd256,  10'd256},  1'b0, '0},
        '{'{9'd511, 10'd1023, 10'd1023}, 1'b0, '0},
        '{'{9'd1,   10'd257,  10'd513},  1'b0, '0},
        '{'{9'd45,  10'd1,    10'd1},    1'b0, '0},
        '{'{9'd90,  10'd255,  10'd511},  1'b0, '0},
        '{'{9'd300, 10'd511,  10'd700},  1'b0, '0},
        '{'{9'd30,  10'd100,  10'd200},  1'b0, '0}
    };

    logic  clk;
    logic  rst_n;
    logic  hsi_valid;
    logic  hsi_ready;
    hsi_t  hsi;
    logic  rgbw_valid;
    logic  rgbw_ready;
    rgbw_t rgbw;

    longint sector_ratio [SECTOR_DEG];
    rgbw_t  pending_rgbw [$];
    rgbw_t  oldest_rgbw;
    int     mismatch_count;
    int     pixels_sent;
    int     pixels_checked;
    int     sector_hits [3];
    int     idle_cycles;
    logic   calm;

    hsi_to_rgbw_converter_core #(
        .RATIO_FRAC_BITS(FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsi_valid (hsi_valid),
        .hsi_ready (hsi_ready),
        .hsi       (hsi),
        .rgbw_valid(rgbw_valid),
        .rgbw_ready(rgbw_ready),
        .rgbw      (rgbw)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // |cos(deg)| in q.30 for deg in 0..90 by truncated series
    function automatic longint unsigned cos_deg_q30(input int unsigned deg);
        longint unsigned x;
        longint unsigned xsq;
        longint unsigned t;
        longint          acc;
        x   = (longint'(deg) * PI_Q30) / 180;
        xsq = (x * x) >> 30;
        t   = ONE_Q30;
        acc = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++)
        begin
            t = ((t * xsq) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        return longint'(acc);
    endfunction

    // ratio table cos(a)/cos(60-a), signed, FRAC fraction bits
    initial
    begin
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        int unsigned     na;
        int unsigned     da;
        for (int unsigned a = 0; a < SECTOR_DEG; a++)
        begin
            na  = (a > 90) ? 180 - a : a;
            da  = (a > 60) ? a - 60 : 60 - a;
            num = cos_deg_q30(na);
            den = cos_deg_q30(da);
            if (den == 0)
                den = 1;
            mag = ((num << FRAC) + den / 2) / den;
            sector_ratio[a] = (a > 90) ? -longint'(mag) : longint'(mag);
        end
    end

    // expected drive levels for one pixel
    function automatic rgbw_t convert_hsi(input hsi_t px);
        int unsigned     h;
        int unsigned     angle;
        sector_t         sect;
        longint unsigned s;
        longint unsigned i;
        longint          lead_w;
        longint          next_w;
        longint unsigned base;
        longint unsigned div3;
        longint unsigned lead;
        longint unsigned nxt;
        longint unsigned wht;
        rgbw_t           res;
        h     = px.hue_degrees % HUE_WRAP;
        sect  = sector_t'(h / SECTOR_DEG);
        angle = h % SECTOR_DEG;
        s     = (px.saturation > SAT_ONE) ? SAT_ONE : px.saturation;
        i     = (px.intensity > INT_LIMIT) ? INT_LIMIT : px.intensity;
        lead_w = (longint'(1) << FRAC) + sector_ratio[angle];
        next_w = (longint'(2) << FRAC) - sector_ratio[angle];
        if (lead_w < 0)
            lead_w = 0;
        if (next_w < 0)
            next_w = 0;
        base = s * CHAN_MAX * i;
        div3 = longint'(3) << (16 + FRAC);
        lead = (base * longint'(lead_w)) / div3;
        nxt  = (base * longint'(next_w)) / div3;
        wht  = (CHAN_MAX * (SAT_ONE - s) * i) >> 16;
        if (lead > CHAN_MAX)
            lead = CHAN_MAX;
        if (nxt > CHAN_MAX)
            nxt = CHAN_MAX;
        if (wht > CHAN_MAX)
            wht = CHAN_MAX;
        res       = '0;
        res.white = wht[7:0];
        case (sect)
            SECT_RED_LEAD:
            begin
                res.red   = lead[7:0];
                res.green = nxt[7:0];
            end
            SECT_GREEN_LEAD:
            begin
                res.green = lead[7:0];
                res.blue  = nxt[7:0];
            end
            default:
            begin
                res.blue = lead[7:0];
                res.red  = nxt[7:0];
            end
        endcase
        return res;
    endfunction

    // drive one pixel beat after an optional idle burst, queue its expected result
    task automatic send_pixel(input hsi_t px, input logic known, input rgbw_t want);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            hsi_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        hsi_valid <= 1'b1;
        hsi       <= px;
        @(posedge clk);
        while (!hsi_ready)
            @(posedge clk);
        pending_rgbw.push_back(known ? want : convert_hsi(px));
        sector_hits[(px.hue_degrees % HUE_WRAP) / SECTOR_DEG]++;
        pixels_sent++;
    endtask

    task automatic report_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rgbw_valid && rgbw_ready)
        begin
            if (pending_rgbw.size() == 0)
            begin
                $error("rgbw beat with nothing expected: %h", rgbw);
                mismatch_count++;
            end
            else
            begin
                oldest_rgbw = pending_rgbw.pop_front();
                pixels_checked++;
                report_field("red", oldest_rgbw.red, rgbw.red);
                report_field("green", oldest_rgbw.green, rgbw.green);
                report_field("blue", oldest_rgbw.blue, rgbw.blue);
                report_field("white", oldest_rgbw.white, rgbw.white);
            end
        end
    end

    // output stall bursts, none once the run is calm
    initial
    begin
        int stall;
        rgbw_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 17);
                @(negedge clk);
                rgbw_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rgbw_ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge clk);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsi_valid && hsi_ready) || (rgbw_valid && rgbw_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without a beat", STALL_LIMIT);
                $display("hsi_to_rgbw_converter_core_test failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        hsi_t px;
        rst_n          = 1'b0;
        hsi_valid      = 1'b0;
        hsi            = '0;
        calm           = 1'b0;
        mismatch_count = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        idle_cycles    = 0;
        sector_hits    = '{0, 0, 0};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int n = 0; n < NUM_PROBES; n++)
            send_pixel(PROBES[n].px, PROBES[n].known, PROBES[n].want);

        // random pixels, mostly within the clamp limits
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == CALM_START)
                calm = 1'b1;
            px.hue_degrees = 9'($urandom_range(0, 511));
            case ($urandom_range(0, 9))
                0:       px.saturation = 10'(SAT_ONE);
                1:       px.saturation = '0;
                2, 3:    px.saturation = 10'($urandom_range(SAT_ONE + 1, 1023));
                default: px.saturation = 10'($urandom_range(0, SAT_ONE));
            endcase
            case ($urandom_range(0, 9))
                0:       px.intensity = 10'(INT_LIMIT);
                1:       px.intensity = '0;
                2, 3:    px.intensity = 10'($urandom_range(INT_LIMIT + 1, 1023));
                default: px.intensity = 10'($urandom_range(0, INT_LIMIT));
            endcase
            send_pixel(px, 1'b0, '0);
        end
        @(negedge clk);
        hsi_valid <= 1'b0;

        // drain, then watch for stray beats
        while (pending_rgbw.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d pixels (%0d directed), checked %0d results",
                 pixels_sent, NUM_PROBES, pixels_checked);
        $display("hue sectors red/green/blue lead: %0d/%0d/%0d, mismatches: %0d",
                 sector_hits[0], sector_hits[1], sector_hits[2], mismatch_count);
        if (mismatch_count == 0 && pending_rgbw.size() == 0)
            $display("hsi_to_rgbw_converter_core_test passed");
        else
            $display("hsi_to_rgbw_converter_core_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/h2rgbw_pkg.sv
rtl/hsi_to_rgbw_converter_core.sv
tb/hsi_to_rgbw_converter_core_test.sv
